### src/nmb_pkg.sv
// ----------------------------------------------------------------------------
// nmb_pkg
// shared types and constants of the neighbor mean blur
// ----------------------------------------------------------------------------
package nmb_pkg;

    // default largest frame side, in pixels
    localparam int MAX_SIDE_DEF = 256;

    // smallest frame side that the size registers hold
    localparam int MIN_SIDE = 2;

    // channel and pixel widths
    localparam int CHAN_W  = 8;
    localparam int NUM_CH  = 3;
    localparam int PIXEL_W = CHAN_W * NUM_CH;

    // neighbors around one pixel, center excluded
    localparam int NUM_CELLS = 8;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // divisor codes: number of neighbors inside the frame
    localparam int DIV_W = 2;

    localparam logic [DIV_W-1:0] DIV_3 = 2'd0;
    localparam logic [DIV_W-1:0] DIV_5 = 2'd1;
    localparam logic [DIV_W-1:0] DIV_8 = 2'd2;

    typedef logic [PIXEL_W-1:0] pixel_t;

    // control from the window stage to each channel lane
    typedef struct packed {
        logic                 load;
        logic [NUM_CELLS-1:0] mask;
        logic [DIV_W-1:0]     div;
    } lane_ctl_t;

endpackage

### src/nmb_line_bank.sv
// ----------------------------------------------------------------------------
// nmb_line_bank
// one line store bank: single address, read-before-write, registered read
// ----------------------------------------------------------------------------
module nmb_line_bank
    import nmb_pkg::*;
#(
    parameter int DEPTH  = MAX_SIDE_DEF,
    parameter int DATA_W = PIXEL_W
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] line_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= line_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/nmb_lane.sv
// ----------------------------------------------------------------------------
// nmb_lane
// one color channel: masked sum of the eight neighbors, then mean
// ----------------------------------------------------------------------------
module nmb_lane
    import nmb_pkg::*;
(
    input  logic                              clk,
    input  lane_ctl_t                         ctl,
    input  logic [NUM_CELLS-1:0][CHAN_W-1:0]  cells,
    output logic [CHAN_W-1:0]                 mean
);

    localparam int SUM_W  = CHAN_W + $clog2(NUM_CELLS);
    localparam int PROD_W = 2 * SUM_W;

    // floor(s/3) = (s * 683) >> 11 for s up to 765
    localparam int RECIP_3 = 683;
    localparam int SHIFT_3 = 11;
    // floor(s/5) = (s * 1639) >> 13 for s up to 1275
    localparam int RECIP_5 = 1639;
    localparam int SHIFT_5 = 13;
    localparam int SHIFT_8 = 3;

    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [PROD_W-1:0] prod3;
    logic [PROD_W-1:0] prod5;

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < NUM_CELLS; k++)
        begin
            if (ctl.mask[k])
            begin
                sum_next = sum_next + SUM_W'(cells[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            sum_reg <= sum_next;
            div_reg <= ctl.div;
        end
    end

    assign prod3 = PROD_W'(sum_reg) * PROD_W'(RECIP_3);
    assign prod5 = PROD_W'(sum_reg) * PROD_W'(RECIP_5);

    always_comb
    begin
        unique case (div_reg)
            DIV_3:   mean = prod3[SHIFT_3 +: CHAN_W];
            DIV_5:   mean = prod5[SHIFT_5 +: CHAN_W];
            DIV_8:   mean = sum_reg[SHIFT_8 +: CHAN_W];
            default: mean = '0;
        endcase
    end

endmodule

### src/neighbor_mean_blur.sv
// ----------------------------------------------------------------------------
// neighbor_mean_blur
// 3x3 neighbor mean blur over an RGB raster stream, center excluded
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order while the output is not stalled
// and returns, per channel, the truncated mean of the pixel's neighbors that
// lie inside the frame (8 inside, 5 on an edge, 3 at a corner). A result
// leaves one row plus one pixel after its pixel enters; after the last frame
// pixel send frame_width+1 padding transfers (tuser high) to flush the
// remaining results, the final one carries tlast. Padding sent while the frame
// is still arriving is taken and dropped. Sustained rate is one transfer per
// cycle in both directions while m_tready stays high: both line store banks
// are read and the bank of the row's parity is written at the same column
// per cycle, and the three channel lanes work in parallel. The line stores
// need no clearing pass after reset. Frame sizes are written through the cfg
// port (index 0 width, index 1 height), clamped to [2, MAX_SIDE]; the user
// has them changed only while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
module neighbor_mean_blur
    import nmb_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // pixel in
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PIXEL_W-1:0]     s_tdata,   // red_in, green_in, blue_in
    input  logic                   s_tuser,   // kind: 1 = padding transfer

    // blurred pixel out
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [PIXEL_W-1:0]     m_tdata,   // red_out, green_out, blue_out
    output logic                   m_tlast,   // frame_end

    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int ROW_W  = $clog2(MAX_SIDE + 2);
    localparam int CMP_W  = (SIDE_W > CFG_DATA_W) ? SIDE_W : CFG_DATA_W;
    localparam int RESET_SIDE = (MAX_SIDE < 256) ? MAX_SIDE : 256;

    // ------------------------------------------------------------------
    // frame size registers
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0] width_reg;
    logic [SIDE_W-1:0] height_reg;
    logic [CMP_W-1:0]  cfg_ext;
    logic [SIDE_W-1:0] cfg_clamped;

    assign cfg_ready = 1'b1;
    assign cfg_ext   = CMP_W'(cfg_data);

    always_comb
    begin
        if (cfg_ext < CMP_W'(MIN_SIDE))
        begin
            cfg_clamped = SIDE_W'(MIN_SIDE);
        end
        else if (cfg_ext > CMP_W'(MAX_SIDE))
        begin
            cfg_clamped = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            cfg_clamped = cfg_ext[SIDE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIDE_W'(RESET_SIDE);
            height_reg <= SIDE_W'(RESET_SIDE);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_clamped;
                REG_FRAME_HEIGHT: height_reg <= cfg_clamped;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline enables: each stage moves when the one after it has room
    // ------------------------------------------------------------------
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic en1;
    logic en2;
    logic en3;

    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    // ------------------------------------------------------------------
    // stage A: position decode, line store access, counter update
    // ------------------------------------------------------------------
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [ROW_W-1:0]  h_ext;
    logic [SIDE_W-1:0] col_inc;
    logic              fire_in;
    logic              flushing_a;
    logic              last_a;
    logic              drop_a;
    logic              take_a;
    logic              has_a;
    logic [ROW_W-1:0]  cr_a;
    logic [COL_W-1:0]  cc_a;
    logic              up_a;
    logic              down_a;
    logic              left_a;
    logic              right_a;
    logic [NUM_CELLS-1:0] mask_a;
    logic [DIV_W-1:0]  div_a;

    assign h_ext      = ROW_W'(height_reg);
    assign fire_in    = s_tvalid && s_tready;
    assign flushing_a = row_reg >= h_ext;
    assign last_a     = row_reg >= (h_ext + ROW_W'(1));
    // padding that shows up while the frame still arrives is dropped
    assign drop_a     = !flushing_a && s_tuser;
    assign take_a     = fire_in && !drop_a;

    // which center pixel this transfer completes
    always_comb
    begin
        if ((col_reg != '0) && !last_a)
        begin
            has_a = row_reg >= ROW_W'(1);
            cr_a  = row_reg - ROW_W'(1);
            cc_a  = col_reg - COL_W'(1);
        end
        else
        begin
            // wrap to the last column of the row two back
            has_a = row_reg >= ROW_W'(2);
            cr_a  = row_reg - ROW_W'(2);
            cc_a  = COL_W'(width_reg - SIDE_W'(1));
        end
    end

    assign up_a    = cr_a != '0;
    assign down_a  = (cr_a + ROW_W'(1)) < h_ext;
    assign left_a  = cc_a != '0;
    assign right_a = (SIDE_W'(cc_a) + SIDE_W'(1)) < width_reg;

    // mask order: left column up/mid/down, up, down, right column up/mid/down
    assign mask_a = {right_a & down_a, right_a, right_a & up_a,
                     down_a, up_a,
                     left_a & down_a, left_a, left_a & up_a};

    always_comb
    begin
        if (up_a && down_a && left_a && right_a)
        begin
            div_a = DIV_8;
        end
        else if ((up_a ^ down_a) && (left_a ^ right_a))
        begin
            div_a = DIV_3;
        end
        else
        begin
            div_a = DIV_5;
        end
    end

    assign col_inc = SIDE_W'(col_reg) + SIDE_W'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (take_a)
        begin
            if (last_a)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_inc >= width_reg)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // two line store banks picked by row parity; the bank of the current
    // row gives the row two back before it is overwritten
    pixel_t rd_data [2];

    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        nmb_line_bank #(
            .DEPTH  (MAX_SIDE),
            .DATA_W (PIXEL_W)
        ) u_bank (
            .clk   (clk),
            .wr_en (take_a && !flushing_a && (row_reg[0] == 1'(b))),
            .rd_en (take_a),
            .addr  (col_reg),
            .wdata (s_tdata),
            .rdata (rd_data[b])
        );
    end

    // ------------------------------------------------------------------
    // stage 1: line store data arrives, window shift
    // ------------------------------------------------------------------
    pixel_t               pix1_reg;
    logic                 par1_reg;
    logic                 has1_reg;
    logic                 last1_reg;
    logic [NUM_CELLS-1:0] mask1_reg;
    logic [DIV_W-1:0]     div1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= take_a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && take_a)
        begin
            // flush transfers push an empty bottom row
            pix1_reg  <= flushing_a ? '0 : s_tdata;
            par1_reg  <= row_reg[0];
            has1_reg  <= has_a;
            last1_reg <= last_a;
            mask1_reg <= mask_a;
            div1_reg  <= div_a;
        end
    end

    pixel_t nc0;
    pixel_t nc1;
    pixel_t nc2;
    pixel_t window_reg [6];

    assign nc0 = par1_reg ? rd_data[1] : rd_data[0];
    assign nc1 = par1_reg ? rd_data[0] : rd_data[1];
    assign nc2 = pix1_reg;

    // two columns of three rows; the newest column comes from nc0..nc2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (v1_reg && en2)
        begin
            window_reg[0] <= window_reg[3];
            window_reg[1] <= window_reg[4];
            window_reg[2] <= window_reg[5];
            window_reg[3] <= nc0;
            window_reg[4] <= nc1;
            window_reg[5] <= nc2;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: channel lanes sum and divide
    // ------------------------------------------------------------------
    lane_ctl_t   lane_ctl;
    logic        last2_reg;
    logic [CHAN_W-1:0] lane_mean [NUM_CH];

    assign lane_ctl.load = v1_reg && has1_reg && en2;
    assign lane_ctl.mask = mask1_reg;
    assign lane_ctl.div  = div1_reg;

    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_lane
        logic [NUM_CELLS-1:0][CHAN_W-1:0] cells;

        assign cells[0] = window_reg[0][ch*CHAN_W +: CHAN_W];
        assign cells[1] = window_reg[1][ch*CHAN_W +: CHAN_W];
        assign cells[2] = window_reg[2][ch*CHAN_W +: CHAN_W];
        assign cells[3] = window_reg[3][ch*CHAN_W +: CHAN_W];
        assign cells[4] = window_reg[5][ch*CHAN_W +: CHAN_W];
        assign cells[5] = nc0[ch*CHAN_W +: CHAN_W];
        assign cells[6] = nc1[ch*CHAN_W +: CHAN_W];
        assign cells[7] = nc2[ch*CHAN_W +: CHAN_W];

        nmb_lane u_lane (
            .clk   (clk),
            .ctl   (lane_ctl),
            .cells (cells),
            .mean  (lane_mean[ch])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg && has1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane_ctl.load)
        begin
            last2_reg <= last1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: merge the lanes into the output register
    // ------------------------------------------------------------------
    pixel_t data3_reg;
    logic   last3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            data3_reg <= {lane_mean[2], lane_mean[1], lane_mean[0]};
            last3_reg <= last2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = data3_reg;
    assign m_tlast  = last3_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        take_a && last_a |=> (col_reg == '0) && (row_reg == '0))
        else $error("position not cleared after final transfer");

    a_drop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fire_in && drop_a |=> $stable(col_reg) && $stable(row_reg))
        else $error("dropped padding moved the position");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(MAX_SIDE - 1))
        else $error("column counter out of range");

    a_lane_count: assert property (@(posedge clk) disable iff (!rst_n)
        lane_ctl.load |-> ($countones(lane_ctl.mask) == 3
                        || $countones(lane_ctl.mask) == 5
                        || $countones(lane_ctl.mask) == 8))
        else $error("neighbor count not 3, 5 or 8");

endmodule
